// File: hdl/modbus_response_checker_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Modbus response checker
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MODBUS_RESPONSE_CHECKER_MACROS_SVH
`define MODBUS_RESPONSE_CHECKER_MACROS_SVH

// Implication checked at every clock edge out of reset
`define MBRC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MBRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Invariant
`define MBRC_ASSERT_ALWAYS(lbl, expr, msg) \
    `MBRC_ASSERT_IMP(lbl, 1'b1, expr, msg)

`endif

// File: hdl/mbrc_pkg.sv
// ---------------------------------------------------------------------------
// mbrc_pkg
// Types, codes and helpers shared by the Modbus response checker.
// ---------------------------------------------------------------------------
package mbrc_pkg;

    localparam int MAX_RESPONSE_BYTES_DEF = 256;
    localparam int RES_FIFO_DEPTH         = 4;
    localparam int EXP_W                  = 12;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WORK_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_KIND        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_FUNCTION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_QUANTITY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS     = 3'd4;

    // work modes
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_LENGTH   = 3'd1;
    localparam logic [2:0] ERR_COMMAND  = 3'd2;
    localparam logic [2:0] ERR_MISMATCH = 3'd3;
    localparam logic [2:0] ERR_MODE     = 3'd4;

    localparam logic [7:0] EXC_FLAG = 8'h80;

    typedef struct packed {
        logic [1:0]  work_mode;
        logic [1:0]  table_kind;
        logic [6:0]  expected_function;
        logic [10:0] item_quantity;
        logic [15:0] start_address;
    } t_cfg;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] response_byte;
        logic       end_of_response;
    } t_rsp_item;

    typedef struct packed {
        logic        result_kind;
        logic [10:0] data_index;
        logic [15:0] data_value;
        logic [3:0]  bit_count;
        logic [2:0]  error_code;
        logic        response_ok;
        logic        last_result;
    } t_res_item;

    // up to two results per byte: a data item, then the status
    typedef struct packed {
        logic [1:0] cnt;
        t_res_item  item0;
        t_res_item  item1;
    } t_res_push;

    // Payload bytes a well-formed read reply must carry
    function automatic logic [EXP_W-1:0] expected_bytes(input logic [1:0]  table_kind,
                                                        input logic [10:0] quantity);
        logic [EXP_W-1:0] q;
        q = EXP_W'(quantity);
        if (!table_kind[1]) begin
            expected_bytes = q << 1;
        end else begin
            expected_bytes = (q + EXP_W'(7)) >> 3;
        end
    endfunction

endpackage

// File: hdl/mbrc_stream_if.sv
// ---------------------------------------------------------------------------
// mbrc_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ---------------------------------------------------------------------------
interface mbrc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

// File: hdl/modbus_response_checker.sv
// ---------------------------------------------------------------------------
// modbus_response_checker
// Checks a Modbus response PDU byte by byte and unpacks its data.
// ---------------------------------------------------------------------------
// Takes one response byte per cycle on i_rsp and returns decoded registers or
// coil groups, then a final status, on o_res. A byte is held in the input
// register, is decoded against the run state, and its results land in a
// four-entry result queue that drives o_res. A byte is taken every cycle
// while the queue has room for two results; a closing byte that also
// completes a data word yields two results, which leave at one per cycle
// while o_res is ready. Configuration writes take effect on the next byte
// and are meant for idle periods between responses.
module modbus_response_checker #(
    parameter int MAX_RESPONSE_BYTES = mbrc_pkg::MAX_RESPONSE_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mbrc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mbrc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    mbrc_stream_if.sink                        i_rsp,
    mbrc_stream_if.source                      o_res
);
    mbrc_pkg::t_cfg      r_cfg;
    mbrc_pkg::t_res_push push;
    logic                room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.work_mode         <= '0;
            r_cfg.table_kind        <= '0;
            r_cfg.expected_function <= 7'd3;
            r_cfg.item_quantity     <= 11'd1;
            r_cfg.start_address     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mbrc_pkg::CFG_WORK_MODE:         r_cfg.work_mode         <= i_cfg_data[1:0];
                mbrc_pkg::CFG_TABLE_KIND:        r_cfg.table_kind        <= i_cfg_data[1:0];
                mbrc_pkg::CFG_EXPECTED_FUNCTION: r_cfg.expected_function <= i_cfg_data[6:0];
                mbrc_pkg::CFG_ITEM_QUANTITY:     r_cfg.item_quantity     <= i_cfg_data[10:0];
                mbrc_pkg::CFG_START_ADDRESS:     r_cfg.start_address     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mbrc_core #(
        .MAX_RESPONSE_BYTES(MAX_RESPONSE_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_room  (room),
        .i_rsp   (i_rsp),
        .o_push  (push)
    );

    mbrc_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_res   (o_res)
    );

endmodule

// File: hdl/mbrc_res_fifo.sv
// ---------------------------------------------------------------------------
// mbrc_res_fifo
// Small result queue: takes up to two results a cycle, sends one a cycle while o_res is ready.
// ---------------------------------------------------------------------------
`include "modbus_response_checker_macros.svh"

module mbrc_res_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbrc_pkg::t_res_push i_push,
    output logic                o_room,
    mbrc_stream_if.source       o_res
);
    localparam int DEPTH = mbrc_pkg::RES_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mbrc_pkg::t_res_item r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wp, r_rp;
    logic [CNT_W-1:0]    r_count;
    logic                pop;
    logic [PTR_W-1:0]    wp_next;

    assign o_res.valid   = (r_count != '0);
    assign o_res.payload = r_mem[r_rp];
    assign pop           = o_res.valid & o_res.ready;
    assign wp_next       = r_wp + PTR_W'(1);
    // room for a full pair, counted before this cycle's pop
    assign o_room        = (r_count <= CNT_W'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.item0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wp_next] <= i_push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + PTR_W'(i_push.cnt);
            if (pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push.cnt) - CNT_W'(pop);
        end
    end

    `MBRC_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(DEPTH), "result queue overflow")
    `MBRC_ASSERT_IMP(a_push_room, i_push.cnt != 2'd0, o_room, "push without room for a pair")

endmodule

// File: hdl/mbrc_core.sv
// ---------------------------------------------------------------------------
// mbrc_core
// Input register and per-byte decode of the response PDU.
// ---------------------------------------------------------------------------
`include "modbus_response_checker_macros.svh"

module mbrc_core #(
    parameter int MAX_RESPONSE_BYTES = mbrc_pkg::MAX_RESPONSE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbrc_pkg::t_cfg      i_cfg,
    input  logic                i_room,
    mbrc_stream_if.sink         i_rsp,
    output mbrc_pkg::t_res_push o_push
);
    localparam int POS_W = $clog2(MAX_RESPONSE_BYTES + 1);
    localparam int EXP_W = mbrc_pkg::EXP_W;
    localparam int CMP_W = ((POS_W > EXP_W) ? POS_W : EXP_W) + 1;

    logic                  r_in_valid;
    mbrc_pkg::t_rsp_item   r_in;
    logic                  fire;

    logic [POS_W-1:0] r_pos,  n_pos;
    logic [2:0]       r_err,  n_err;
    logic [7:0]       r_bc,   n_bc;
    logic [7:0]       r_held, n_held;
    logic [15:0]      r_echo_addr, n_echo_addr;
    logic [15:0]      r_echo_qty,  n_echo_qty;
    logic             r_exc,  n_exc;

    logic                emit;
    mbrc_pkg::t_res_item data_item, stat_item;
    logic [2:0]          fin_err;
    logic [7:0]          b;
    logic                take, mode_ok, is_read;
    logic [EXP_W-1:0]    exp_bytes;
    logic [POS_W-1:0]    d;
    logic [10:0]         first, left;
    logic [3:0]          cnt;
    logic [8:0]          mask;

    assign fire        = r_in_valid & i_room;
    assign i_rsp.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rsp.valid && i_rsp.ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rsp.valid && i_rsp.ready) begin
            r_in <= i_rsp.payload;
        end
    end

    always_comb begin
        b         = r_in.response_byte;
        mode_ok   = (i_cfg.work_mode == mbrc_pkg::MODE_READ) ||
                    (i_cfg.work_mode == mbrc_pkg::MODE_WRITE);
        is_read   = (i_cfg.work_mode == mbrc_pkg::MODE_READ);
        take      = r_in.has_byte && (r_pos < POS_W'(MAX_RESPONSE_BYTES));
        exp_bytes = mbrc_pkg::expected_bytes(i_cfg.table_kind, i_cfg.item_quantity);
        d         = r_pos - POS_W'(2);
        first     = 11'({d, 3'b000});
        left      = i_cfg.item_quantity - first;
        cnt       = (left < 11'd8) ? left[3:0] : 4'd8;
        mask      = (9'd1 << cnt) - 9'd1;

        n_pos       = r_pos;
        n_err       = r_err;
        n_bc        = r_bc;
        n_held      = r_held;
        n_echo_addr = r_echo_addr;
        n_echo_qty  = r_echo_qty;
        n_exc       = r_exc;
        emit        = 1'b0;
        data_item   = '0;
        data_item.result_kind = mbrc_pkg::KIND_DATA;

        if (take) begin
            n_pos = r_pos + POS_W'(1);
            if (mode_ok) begin
                if (r_pos == '0) begin
                    if (b == {1'b0, i_cfg.expected_function}) begin
                        n_exc = r_exc;
                    end else if (b == (mbrc_pkg::EXC_FLAG | {1'b0, i_cfg.expected_function})) begin
                        n_exc = 1'b1;
                    end else begin
                        n_err = mbrc_pkg::ERR_COMMAND;
                    end
                end else if (r_err == mbrc_pkg::ERR_NONE && !r_exc) begin
                    if (!is_read) begin
                        // echoed address then quantity, high byte first
                        if (r_pos == POS_W'(1)) begin
                            n_echo_addr[15:8] = b;
                        end else if (r_pos == POS_W'(2)) begin
                            n_echo_addr[7:0] = b;
                        end else if (r_pos == POS_W'(3)) begin
                            n_echo_qty[15:8] = b;
                        end else if (r_pos == POS_W'(4)) begin
                            n_echo_qty[7:0] = b;
                        end
                    end else if (r_pos == POS_W'(1)) begin
                        n_bc = b;
                    end else if ((EXP_W'(r_bc) == exp_bytes) &&
                                 (CMP_W'(d) < CMP_W'(exp_bytes))) begin
                        if (!i_cfg.table_kind[1]) begin
                            if (!d[0]) begin
                                n_held = b;
                            end else begin
                                emit                 = 1'b1;
                                data_item.data_index = 11'(d >> 1);
                                data_item.data_value = {r_held, b};
                            end
                        end else begin
                            emit                 = 1'b1;
                            data_item.data_index = first;
                            data_item.data_value = {8'h00, b & mask[7:0]};
                            data_item.bit_count  = cnt;
                        end
                    end
                end
            end
        end

        // final status, from the state after this byte
        if (n_pos == '0) begin
            fin_err = mbrc_pkg::ERR_LENGTH;
        end else if (!mode_ok) begin
            fin_err = mbrc_pkg::ERR_MODE;
        end else if (n_err != mbrc_pkg::ERR_NONE) begin
            fin_err = n_err;
        end else if (n_exc) begin
            fin_err = (n_pos >= POS_W'(2)) ? mbrc_pkg::ERR_MISMATCH : mbrc_pkg::ERR_LENGTH;
        end else if (is_read) begin
            if ((n_pos < POS_W'(2)) || (EXP_W'(n_bc) != exp_bytes) ||
                (CMP_W'(n_pos) < CMP_W'(exp_bytes) + CMP_W'(2))) begin
                fin_err = mbrc_pkg::ERR_LENGTH;
            end else begin
                fin_err = mbrc_pkg::ERR_NONE;
            end
        end else if (n_pos < POS_W'(5)) begin
            fin_err = mbrc_pkg::ERR_LENGTH;
        end else if (n_echo_addr != i_cfg.start_address) begin
            fin_err = mbrc_pkg::ERR_MISMATCH;
        end else if ((i_cfg.item_quantity > 11'd1) &&
                     (n_echo_qty != 16'(i_cfg.item_quantity))) begin
            fin_err = mbrc_pkg::ERR_MISMATCH;
        end else begin
            fin_err = mbrc_pkg::ERR_NONE;
        end

        stat_item             = '0;
        stat_item.result_kind = mbrc_pkg::KIND_STATUS;
        stat_item.error_code  = fin_err;
        stat_item.response_ok = (fin_err == mbrc_pkg::ERR_NONE);
        stat_item.last_result = 1'b1;

        o_push.cnt   = fire ? (2'(emit) + 2'(r_in.end_of_response)) : 2'd0;
        o_push.item0 = emit ? data_item : stat_item;
        o_push.item1 = stat_item;

        if (r_in.end_of_response) begin
            n_pos       = '0;
            n_err       = mbrc_pkg::ERR_NONE;
            n_bc        = '0;
            n_held      = '0;
            n_echo_addr = '0;
            n_echo_qty  = '0;
            n_exc       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_err       <= mbrc_pkg::ERR_NONE;
            r_bc        <= '0;
            r_held      <= '0;
            r_echo_addr <= '0;
            r_echo_qty  <= '0;
            r_exc       <= 1'b0;
        end else if (fire) begin
            r_pos       <= n_pos;
            r_err       <= n_err;
            r_bc        <= n_bc;
            r_held      <= n_held;
            r_echo_addr <= n_echo_addr;
            r_echo_qty  <= n_echo_qty;
            r_exc       <= n_exc;
        end
    end

    `MBRC_ASSERT_NEXT(a_clear_on_end, fire && r_in.end_of_response, (r_pos == '0) && (r_err == mbrc_pkg::ERR_NONE) && !r_exc, "run state not cleared after status")
    `MBRC_ASSERT_ALWAYS(a_err_exc_excl, !(r_exc && (r_err != mbrc_pkg::ERR_NONE)), "exception and command error both set")
    `MBRC_ASSERT_ALWAYS(a_pos_bound, r_pos <= POS_W'(MAX_RESPONSE_BYTES), "byte position past limit")

endmodule
